// ----- hw/rtl/ppr_pkg.sv -----
package ppr_pkg;

   localparam int SYMBOL_W = 4;
   localparam int RANK_W = 29;
   localparam int CFG_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int TBL_DIM = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_SIZE   = 2'd0,
      CSR_PICK_COUNT = 2'd1
   } csr_index_type;

   localparam logic [CFG_W-1:0] SET_SIZE_RESET = 4'd12;
   localparam logic [CFG_W-1:0] PICK_COUNT_RESET = 4'd12;

   typedef logic [TBL_DIM-1:0][TBL_DIM-1:0][RANK_W-1:0] weight_tbl_type;

   // P(a, b) = a * (a-1) * ... * (a-b+1), kept modulo 2^RANK_W
   function automatic weight_tbl_type build_weights();
      weight_tbl_type tbl;
      logic [63:0] p;
      for (int a = 0; a < TBL_DIM; a++) begin
         for (int b = 0; b < TBL_DIM; b++) begin
            p = 64'd1;
            for (int j = 0; j < b && j < a; j++) begin
               p = (p * 64'(a - j)) & ((64'd1 << RANK_W) - 64'd1);
            end
            tbl[SYMBOL_W'(a)][SYMBOL_W'(b)] = p[RANK_W-1:0];
         end
      end
      return tbl;
   endfunction

   localparam weight_tbl_type WEIGHT_TBL = build_weights();

   typedef struct packed {
      logic [SYMBOL_W-1:0] position;
      logic                error;
      logic                done;
   } step_status_type;

endpackage

// ----- hw/rtl/ppr_step.sv -----
module ppr_step import ppr_pkg::*; #(
   parameter int MAX_SYMBOLS = 12
) (
   input  logic [SYMBOL_W-1:0]    symbol,
   input  logic [SYMBOL_W-1:0]    n_eff,
   input  logic [SYMBOL_W-1:0]    k_eff,
   input  logic [MAX_SYMBOLS-1:0] seen_mask,
   input  logic [SYMBOL_W-1:0]    position,
   input  logic [RANK_W-1:0]      rank,
   input  logic                   error,
   output logic [MAX_SYMBOLS-1:0] seen_mask_next,
   output logic [RANK_W-1:0]      rank_next,
   output step_status_type        status
);

   localparam int WIDE_W = 1 << SYMBOL_W;

   logic [WIDE_W-1:0]       mask_wide;
   logic [WIDE_W-1:0]       below_mask;
   logic [WIDE_W-1:0]       mask_set;
   logic [SYMBOL_W:0]       below_cnt;
   logic [SYMBOL_W-1:0]     digit;
   logic [SYMBOL_W-1:0]     idx;
   logic [SYMBOL_W-1:0]     tbl_a;
   logic [SYMBOL_W-1:0]     tbl_b;
   logic [RANK_W-1:0]       weight;
   logic [RANK_W-1:0]       product;
   logic                    fresh;
   logic                    bad;
   logic [SYMBOL_W-1:0]     pos_inc;

   // a stale position (never expected) restarts the sequence
   assign fresh = (position >= k_eff);
   assign idx = fresh ? '0 : position;
   assign mask_wide = fresh ? '0 : WIDE_W'(seen_mask);

   assign bad = (symbol >= n_eff) || mask_wide[symbol];
   assign below_mask = mask_wide & ((WIDE_W'(1) << symbol) - WIDE_W'(1));

   always_comb begin
      below_cnt = '0;
      for (int b = 0; b < WIDE_W; b++) begin
         below_cnt = below_cnt + (SYMBOL_W+1)'(below_mask[SYMBOL_W'(b)]);
      end
   end

   assign digit = symbol - below_cnt[SYMBOL_W-1:0];
   assign tbl_a = n_eff - idx - SYMBOL_W'(1);
   assign tbl_b = k_eff - idx - SYMBOL_W'(1);
   assign weight = WEIGHT_TBL[tbl_a][tbl_b];
   assign product = RANK_W'(weight * RANK_W'(digit));

   assign mask_set = mask_wide | (WIDE_W'(1) << symbol);
   assign pos_inc = idx + SYMBOL_W'(1);

   always_comb begin
      status.done = (pos_inc >= k_eff);
      status.error = (fresh ? 1'b0 : error) | bad;
      status.position = pos_inc;
      if (bad) begin
         rank_next = fresh ? '0 : rank;
         seen_mask_next = mask_wide[MAX_SYMBOLS-1:0];
      end else begin
         rank_next = (fresh ? '0 : rank) + product;
         seen_mask_next = mask_set[MAX_SYMBOLS-1:0];
      end
   end

endmodule

// ----- hw/rtl/partial_permutation_ranker_unit.sv -----
// Ranks partial permutations of pick_count symbols out of set_size, one symbol
// per req beat, emitting one rsp beat (rank, bad_input) after the last symbol
// of each sequence. Each symbol goes through the step logic behind the input
// register (masked popcount, one table-weight multiply, one add), so a new
// symbol is taken every cycle, stalls aside; rsp_valid rises as the last
// symbol's step result enters the rsp register. While an rsp beat waits, the
// next sequence's last symbol holds in the input register and req_ready drops.
// Writing either CSR discards a partial sequence; write CSRs only while idle.
module partial_permutation_ranker_unit import ppr_pkg::*; #(
   parameter int MAX_SYMBOLS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [SYMBOL_W-1:0]  req_symbol,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [RANK_W-1:0]    rsp_rank,
   output logic                 rsp_bad_input,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam logic [SYMBOL_W:0] MAX_N = (SYMBOL_W+1)'(MAX_SYMBOLS);

   logic [CFG_W-1:0]       set_size_ff, set_size_in;
   logic [CFG_W-1:0]       pick_count_ff, pick_count_in;
   logic                   in_vld_ff, in_vld_in;
   logic [SYMBOL_W-1:0]    symbol_ff, symbol_in;
   logic [MAX_SYMBOLS-1:0] seen_mask_ff, seen_mask_in;
   logic [SYMBOL_W-1:0]    position_ff, position_in;
   logic [RANK_W-1:0]      rank_ff, rank_in;
   logic                   error_ff, error_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [RANK_W-1:0]      rsp_rank_ff, rsp_rank_in;
   logic                   rsp_bad_ff, rsp_bad_in;

   logic [SYMBOL_W-1:0]    n_eff;
   logic [SYMBOL_W-1:0]    k_eff;
   logic [MAX_SYMBOLS-1:0] mask_next;
   logic [RANK_W-1:0]      rank_next;
   step_status_type        st;
   logic                   out_free;
   logic                   step_fire;
   logic                   req_fire;
   logic                   csr_fire;

   always_comb begin
      if (set_size_ff == '0) begin
         n_eff = SYMBOL_W'(1);
      end else if ((SYMBOL_W+1)'(set_size_ff) > MAX_N) begin
         n_eff = MAX_N[SYMBOL_W-1:0];
      end else begin
         n_eff = set_size_ff;
      end
      if (pick_count_ff == '0) begin
         k_eff = SYMBOL_W'(1);
      end else if (pick_count_ff > n_eff) begin
         k_eff = n_eff;
      end else begin
         k_eff = pick_count_ff;
      end
   end

   ppr_step #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_step (
      .symbol         (symbol_ff),
      .n_eff          (n_eff),
      .k_eff          (k_eff),
      .seen_mask      (seen_mask_ff),
      .position       (position_ff),
      .rank           (rank_ff),
      .error          (error_ff),
      .seen_mask_next (mask_next),
      .rank_next      (rank_next),
      .status         (st)
   );

   assign csr_ready = 1'b1;
   assign csr_fire = csr_valid && csr_ready;
   assign out_free = !rsp_vld_ff || rsp_ready;
   assign step_fire = in_vld_ff && (!st.done || out_free);
   assign req_ready = !in_vld_ff || step_fire;
   assign req_fire = req_valid && req_ready;

   always_comb begin
      set_size_in = set_size_ff;
      pick_count_in = pick_count_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_SET_SIZE:   set_size_in = csr_data;
            CSR_PICK_COUNT: pick_count_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_vld_in = req_fire ? 1'b1 : (step_fire ? 1'b0 : in_vld_ff);
      symbol_in = req_fire ? req_symbol : symbol_ff;

      seen_mask_in = seen_mask_ff;
      position_in = position_ff;
      rank_in = rank_ff;
      error_in = error_ff;
      if (csr_fire && (csr_index == CSR_SET_SIZE || csr_index == CSR_PICK_COUNT)) begin
         seen_mask_in = '0;
         position_in = '0;
         rank_in = '0;
         error_in = 1'b0;
      end else if (step_fire) begin
         if (st.done) begin
            seen_mask_in = '0;
            position_in = '0;
            rank_in = '0;
            error_in = 1'b0;
         end else begin
            seen_mask_in = mask_next;
            position_in = st.position;
            rank_in = rank_next;
            error_in = st.error;
         end
      end

      rsp_vld_in = (step_fire && st.done) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);
      rsp_rank_in = (step_fire && st.done) ? rank_next : rsp_rank_ff;
      rsp_bad_in = (step_fire && st.done) ? st.error : rsp_bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff <= SET_SIZE_RESET;
         pick_count_ff <= PICK_COUNT_RESET;
         in_vld_ff <= 1'b0;
         seen_mask_ff <= '0;
         position_ff <= '0;
         rank_ff <= '0;
         error_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         set_size_ff <= set_size_in;
         pick_count_ff <= pick_count_in;
         in_vld_ff <= in_vld_in;
         seen_mask_ff <= seen_mask_in;
         position_ff <= position_in;
         rank_ff <= rank_in;
         error_ff <= error_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff <= symbol_in;
      rsp_rank_ff <= rsp_rank_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_rank = rsp_rank_ff;
   assign rsp_bad_input = rsp_bad_ff;

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      step_fire && st.done |=> rsp_vld_ff)
      else $error("completed sequence did not load rsp register");

   a_pos_below_k: assert property (@(posedge clock) disable iff (reset)
      position_ff < k_eff)
      else $error("position reached pick count");

   a_mask_vs_pos: assert property (@(posedge clock) disable iff (reset)
      $countones(seen_mask_ff) <= 32'(position_ff))
      else $error("more symbols marked seen than received");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !step_fire |-> !req_ready)
      else $error("req taken while input register is stalled");

endmodule

// ----- bench/tb_partial_permutation_ranker_unit.sv -----
`timescale 1ns / 100ps

module tb_partial_permutation_ranker_unit;
   import ppr_pkg::*;

   localparam int SEQ_SYMBOLS   = 12;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int CALM_ITEMS    = 150;
   localparam int QUIET_LIMIT   = 5000;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 20;
   localparam int MAX_REPORTS   = 50;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              bad_input;
   } rank_result_type;

   class rank_tracker_type;
      logic [CFG_W-1:0]       set_size;
      logic [CFG_W-1:0]       pick_count;
      logic [SEQ_SYMBOLS-1:0] seen_mask;
      int unsigned            position;
      logic [RANK_W-1:0]      partial_rank;
      logic                   bad_seen;
      rank_result_type        pending_ranks[$];
      int unsigned            mismatches;

      function new();
         set_size   = SET_SIZE_RESET;
         pick_count = PICK_COUNT_RESET;
         mismatches = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         seen_mask    = '0;
         position     = 0;
         partial_rank = '0;
         bad_seen     = 1'b0;
      endfunction

      function int unsigned symbols_in_set();
         int unsigned n;
         n = 32'(set_size);
         if (n < 1) n = 1;
         if (n > SEQ_SYMBOLS) n = SEQ_SYMBOLS;
         return n;
      endfunction

      function int unsigned sequence_length();
         int unsigned n;
         int unsigned k;
         n = symbols_in_set();
         k = 32'(pick_count);
         if (k < 1) k = 1;
         if (k > n) k = n;
         return k;
      endfunction

      function void take_csr_write(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx == CSR_SET_SIZE) begin
            set_size = val;
            clear_sequence();
         end else if (idx == CSR_PICK_COUNT) begin
            pick_count = val;
            clear_sequence();
         end
      endfunction

      function void take_symbol(logic [SYMBOL_W-1:0] sym);
         int unsigned     n;
         int unsigned     k;
         int unsigned     below;
         int unsigned     span;
         logic [63:0]     weight;
         logic [63:0]     sum;
         rank_result_type res;
         n = symbols_in_set();
         k = sequence_length();
         if (position >= k) clear_sequence();
         if (32'(sym) >= n || seen_mask[sym]) begin
            bad_seen = 1'b1;
         end else begin
            below = 0;
            for (int b = 0; b < int'(sym); b++) below += 32'(seen_mask[SYMBOL_W'(b)]);
            // falling factorial P(n-i-1, k-i-1)
            span   = n - position - 1;
            weight = 64'd1;
            for (int unsigned j = 0; j < k - position - 1 && j < span; j++)
               weight = weight * 64'(span - j);
            sum          = 64'(partial_rank) + 64'(32'(sym) - below) * weight;
            partial_rank = sum[RANK_W-1:0];
            seen_mask[sym] = 1'b1;
         end
         position++;
         if (position >= k) begin
            res.rank      = partial_rank;
            res.bad_input = bad_seen;
            pending_ranks = {pending_ranks, res};
            clear_sequence();
         end
      endfunction

      function void check_rank(logic [RANK_W-1:0] rank, logic bad_input);
         rank_result_type want;
         if (pending_ranks.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected rsp beat rank=%0d bad_input=%0b",
                        $time, rank, bad_input);
            return;
         end
         want = pending_ranks.pop_front();
         if (rank !== want.rank) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: rank mismatch expected=%0d actual=%0d",
                        $time, want.rank, rank);
         end
         if (bad_input !== want.bad_input) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: bad_input mismatch expected=%0b actual=%0b",
                        $time, want.bad_input, bad_input);
         end
      endfunction

      function int unsigned outstanding();
         return pending_ranks.size();
      endfunction
   endclass

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic [SYMBOL_W-1:0]  req_symbol    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic [RANK_W-1:0]    rsp_rank;
   logic                 rsp_bad_input;
   logic                 csr_valid     = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index     = '0;
   logic [CFG_W-1:0]     csr_data      = '0;

   rank_tracker_type tracker;

   int unsigned tx_idle_pct  = 20;
   int unsigned rx_idle_pct  = 20;
   bit          calm         = 1'b0;
   bit          hold_req     = 1'b0;
   int unsigned items_sent   = 0;
   int unsigned quiet_cycles = 0;

   partial_permutation_ranker_unit #(
      .MAX_SYMBOLS(SEQ_SYMBOLS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_symbol    (req_symbol),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rank      (rsp_rank),
      .rsp_bad_input (rsp_bad_input),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : rsp_sink
      int unsigned hold_left;
      int unsigned burst_left;
      hold_left  = 0;
      burst_left = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) tracker.check_rank(rsp_rank, rsp_bad_input);
         if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else if (burst_left != 0) begin
            rsp_ready <= 1'b0;
            burst_left--;
         end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            burst_left = $urandom_range(0, 11);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_symbol(input logic [SYMBOL_W-1:0] sym);
      int unsigned gap;
      if (!calm && tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_symbol <= sym;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_symbol(sym);
      items_sent++;
   endtask

   // distinct symbols from the current set, optionally corrupted
   task automatic send_sequence(input int unsigned len, input int unsigned noise_pct);
      int unsigned         n;
      int unsigned         pool[SEQ_SYMBOLS];
      int unsigned         pick;
      int unsigned         tmp;
      logic [SYMBOL_W-1:0] sym;
      n = tracker.symbols_in_set();
      for (int i = 0; i < SEQ_SYMBOLS; i++) pool[SYMBOL_W'(i)] = i;
      for (int i = 0; i < len; i++) begin
         pick    = $urandom_range(i, n - 1);
         tmp     = pool[SYMBOL_W'(i)];
         pool[SYMBOL_W'(i)] = pool[SYMBOL_W'(pick)];
         pool[SYMBOL_W'(pick)] = tmp;
         sym = SYMBOL_W'(pool[SYMBOL_W'(i)]);
         if ($urandom_range(0, 99) < noise_pct) sym = SYMBOL_W'($urandom_range(0, 15));
         send_symbol(sym);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.take_csr_write(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] k);
      drain_results();
      if ($urandom_range(0, 99) < 15)
         write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, 4'($urandom()));
      if ($urandom_range(0, 1)) begin
         write_csr(CSR_SET_SIZE, n);
         write_csr(CSR_PICK_COUNT, k);
      end else begin
         write_csr(CSR_PICK_COUNT, k);
         write_csr(CSR_SET_SIZE, n);
      end
   endtask

   initial begin : stimulus
      int unsigned n_cfg;
      int unsigned k_cfg;
      int unsigned seq_len;
      int unsigned phase_items;
      int unsigned r;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, highest rank
      for (int s = SEQ_SYMBOLS - 1; s >= 0; s--) send_symbol(SYMBOL_W'(s));

      // repeated and out-of-range symbols
      configure(4'd4, 4'd3);
      send_symbol(4'd3);
      send_symbol(4'd2);
      send_symbol(4'd1);
      send_symbol(4'd0);
      send_symbol(4'd0);
      send_symbol(4'd9);

      // zero registers act as one
      configure(4'd0, 4'd0);
      send_symbol(4'd0);
      send_symbol(4'd15);

      // oversize registers clamp; spare indexes leave a partial sequence alone
      configure(4'd15, 4'd2);
      send_symbol(4'd5);
      drain_results();
      write_csr(CSR_SPARE_A, 4'h0);
      write_csr(CSR_SPARE_B, 4'hF);
      send_symbol(4'd7);

      // output stalled long enough to back up the input
      configure(4'd2, 4'd1);
      tx_idle_pct = 0;
      hold_req    = 1'b1;
      repeat (60) send_symbol(SYMBOL_W'($urandom_range(0, 3)));

      while (items_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            n_cfg = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(12, 15);
            k_cfg = $urandom_range(0, 15);
         end else begin
            n_cfg = $urandom_range(1, 12);
            k_cfg = (r < 25) ? $urandom_range(0, 15) : $urandom_range(1, n_cfg);
         end
         configure(CFG_W'(n_cfg), CFG_W'(k_cfg));
         calm        = (items_sent + CALM_ITEMS >= RANDOM_ITEMS);
         tx_idle_pct = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 40);
         rx_idle_pct = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 40);
         phase_items = $urandom_range(30, 150);
         while (phase_items > 0) begin
            seq_len = tracker.sequence_length();
            if (seq_len > phase_items) seq_len = phase_items;
            send_sequence(seq_len, ($urandom_range(0, 4) == 0) ? 15 : 0);
            phase_items -= seq_len;
         end
      end

      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- partial_permutation_ranker_unit.f -----
hw/rtl/ppr_pkg.sv
hw/rtl/ppr_step.sv
hw/rtl/partial_permutation_ranker_unit.sv
bench/tb_partial_permutation_ranker_unit.sv
